@@ hdl/hse_pkg.sv @@
// Shared types, sizes and the key comparison of the heap sort engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package hse_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int CHILD_W   = ADDR_W + 2;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CHILD_W-1:0]   child_t;

  localparam key_t KEY_SIGN = key_t'(1'b1) << (KEY_WIDTH - 1);

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_HALF,
    IDX_DEC,
    IDX_COUNT,
    IDX_ZERO,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_IDX,
    RD_CHILD,
    RD_CHILD1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_V_NODE,
    WR_BIG_NODE,
    WR_A_IDX
  } wr_sel_e;

  typedef enum logic [1:0] {
    NODE_HOLD,
    NODE_IDX,
    NODE_ZERO,
    NODE_BIG
  } node_op_e;

  typedef enum logic [1:0] {
    SIZE_HOLD,
    SIZE_COUNT,
    SIZE_IDX
  } size_op_e;

  typedef struct packed {
    logic     store_key;
    logic     clear_set;
    idx_op_e  idx_op;
    rd_sel_e  rd_sel;
    wr_sel_e  wr_sel;
    node_op_e node_op;
    size_op_e size_op;
    logic     v_load;
    logic     a_load;
    logic     pick_right;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_le1;
    logic child_in;
    logic right_in;
    logic descend;
    logic out_fire;
    logic out_last;
  } status_t;

  // Strictly greater; signed mode flips the sign bits and compares unsigned.
  function automatic logic key_gt(key_t a, key_t b, logic signed_mode);
    key_t sa;
    key_t sb;
    sa = signed_mode ? (a ^ KEY_SIGN) : a;
    sb = signed_mode ? (b ^ KEY_SIGN) : b;
    return sa > sb;
  endfunction

endpackage

@@ hdl/hse_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stands alone; no package needed.
module hse_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/hse_ctrl.sv @@
// Sequencer of the heap sort engine: load, heap build, extraction, emission.
// Depends on hse_pkg for the command and status structs.
module hse_ctrl
  import hse_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_in_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_BUILD_NEXT,
    S_BUILD_RD,
    S_BUILD_LD,
    S_SORT_NEXT,
    S_SORT_RT,
    S_SORT_SW,
    S_SIFT,
    S_SIFT_L,
    S_SIFT_R,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   build_q, build_d;
  state_e sift_ret;

  assign in_ready_o = (state_q == S_LOAD);
  assign sift_ret   = build_q ? S_BUILD_NEXT : S_SORT_NEXT;

  always_comb begin
    state_d = state_q;
    build_d = build_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.store_key = 1'b1;
          if (last_in_i) begin
            cmd_o.idx_op = IDX_HALF;
            build_d      = 1'b1;
            state_d      = S_BUILD_NEXT;
          end
        end
      end
      S_BUILD_NEXT: begin
        if (status_i.idx_zero) begin
          cmd_o.idx_op = IDX_COUNT;
          build_d      = 1'b0;
          state_d      = S_SORT_NEXT;
        end else begin
          cmd_o.idx_op = IDX_DEC;
          state_d      = S_BUILD_RD;
        end
      end
      S_BUILD_RD: begin
        cmd_o.rd_sel  = RD_IDX;
        cmd_o.node_op = NODE_IDX;
        cmd_o.size_op = SIZE_COUNT;
        state_d       = S_BUILD_LD;
      end
      S_BUILD_LD: begin
        cmd_o.v_load = 1'b1;
        state_d      = S_SIFT;
      end
      S_SORT_NEXT: begin
        if (status_i.idx_le1) begin
          cmd_o.idx_op = IDX_ZERO;
          state_d      = S_EMIT_RD;
        end else begin
          cmd_o.idx_op = IDX_DEC;
          cmd_o.rd_sel = RD_ZERO;
          state_d      = S_SORT_RT;
        end
      end
      S_SORT_RT: begin
        cmd_o.a_load = 1'b1;
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_SORT_SW;
      end
      S_SORT_SW: begin
        cmd_o.v_load  = 1'b1;
        cmd_o.wr_sel  = WR_A_IDX;
        cmd_o.node_op = NODE_ZERO;
        cmd_o.size_op = SIZE_IDX;
        state_d       = S_SIFT;
      end
      S_SIFT: begin
        if (status_i.child_in) begin
          cmd_o.rd_sel = RD_CHILD;
          state_d      = S_SIFT_L;
        end else begin
          cmd_o.wr_sel = WR_V_NODE;
          state_d      = sift_ret;
        end
      end
      S_SIFT_L: begin
        if (status_i.right_in) begin
          cmd_o.a_load = 1'b1;
          cmd_o.rd_sel = RD_CHILD1;
          state_d      = S_SIFT_R;
        end else if (status_i.descend) begin
          cmd_o.wr_sel  = WR_BIG_NODE;
          cmd_o.node_op = NODE_BIG;
          state_d       = S_SIFT;
        end else begin
          cmd_o.wr_sel = WR_V_NODE;
          state_d      = sift_ret;
        end
      end
      S_SIFT_R: begin
        cmd_o.pick_right = 1'b1;
        if (status_i.descend) begin
          cmd_o.wr_sel  = WR_BIG_NODE;
          cmd_o.node_op = NODE_BIG;
          state_d       = S_SIFT;
        end else begin
          cmd_o.wr_sel = WR_V_NODE;
          state_d      = sift_ret;
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_sel = RD_IDX;
        state_d      = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.load_out = 1'b1;
        state_d        = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (status_i.out_fire) begin
          if (status_i.out_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = S_LOAD;
          end else begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      build_q <= build_d;
    end
  end

endmodule

@@ hdl/hse_dpath.sv @@
// Datapath of the heap sort engine: key store, counters, sift compare, output register.
// Depends on hse_pkg and instantiates hse_ram.
module hse_dpath
  import hse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [31:0] key_value_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] sorted_key_o,
  output logic        last_out_o,
  output logic        dropped_o
);

  cnt_t  count_q, count_d;
  logic  ovf_q, ovf_d;
  logic  signed_q;
  cnt_t  idx_q, idx_d;
  addr_t node_q, node_d;
  cnt_t  size_q, size_d;
  key_t  v_q, a_q;
  key_t  out_key_q;
  logic  out_last_q, out_drop_q, out_valid_q;

  logic   full;
  child_t child, child1;
  logic   right_gt;
  key_t   big;
  addr_t  big_idx;
  logic   out_fire;

  logic  ram_we;
  addr_t ram_waddr, ram_raddr;
  key_t  ram_wdata, ram_rdata;

  hse_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(MAX_KEYS)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign full   = (count_q == cnt_t'(MAX_KEYS));
  assign child  = child_t'({node_q, 1'b1});
  assign child1 = child + child_t'(1);

  // Larger child; on a tie the left one wins.
  always_comb begin
    right_gt = key_gt(ram_rdata, a_q, signed_q);
    if (cmd_i.pick_right && right_gt) begin
      big     = ram_rdata;
      big_idx = child1[ADDR_W-1:0];
    end else if (cmd_i.pick_right) begin
      big     = a_q;
      big_idx = child[ADDR_W-1:0];
    end else begin
      big     = ram_rdata;
      big_idx = child[ADDR_W-1:0];
    end
  end

  assign out_fire = out_valid_q && out_ready_i;

  always_comb begin
    status_o.idx_zero = (idx_q == '0);
    status_o.idx_le1  = (idx_q <= cnt_t'(1));
    status_o.child_in = (child < child_t'(size_q));
    status_o.right_in = (child1 < child_t'(size_q));
    status_o.descend  = key_gt(big, v_q, signed_q);
    status_o.out_fire = out_fire;
    status_o.out_last = out_last_q;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = v_q;
    case (cmd_i.wr_sel)
      WR_V_NODE: begin
        ram_we = 1'b1;
      end
      WR_BIG_NODE: begin
        ram_we    = 1'b1;
        ram_wdata = big;
      end
      WR_A_IDX: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[ADDR_W-1:0];
        ram_wdata = a_q;
      end
      default: begin
        ram_we    = cmd_i.store_key && !full;
        ram_waddr = count_q[ADDR_W-1:0];
        ram_wdata = key_t'(key_value_i);
      end
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:    ram_raddr = idx_q[ADDR_W-1:0];
      RD_CHILD:  ram_raddr = child[ADDR_W-1:0];
      RD_CHILD1: ram_raddr = child1[ADDR_W-1:0];
      default:   ram_raddr = '0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.clear_set) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.store_key) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + cnt_t'(1);
      end
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_HALF:  idx_d = count_d >> 1;
      IDX_DEC:   idx_d = idx_q - cnt_t'(1);
      IDX_COUNT: idx_d = count_q;
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_q + cnt_t'(1);
      default:   idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.node_op)
      NODE_IDX:  node_d = idx_q[ADDR_W-1:0];
      NODE_ZERO: node_d = '0;
      NODE_BIG:  node_d = big_idx;
      default:   node_d = node_q;
    endcase
  end

  always_comb begin
    case (cmd_i.size_op)
      SIZE_COUNT: size_d = count_q;
      SIZE_IDX:   size_d = idx_q;
      default:    size_d = size_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      signed_q    <= 1'b0;
      idx_q       <= '0;
      node_q      <= '0;
      size_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      node_q  <= node_d;
      size_q  <= size_d;
      if (cfg_valid_i) begin
        signed_q <= cfg_data_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.v_load) begin
      v_q <= ram_rdata;
    end
    if (cmd_i.a_load) begin
      a_q <= ram_rdata;
    end
    if (cmd_i.load_out) begin
      out_key_q  <= ram_rdata;
      out_last_q <= (idx_q == count_q - cnt_t'(1));
      out_drop_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sorted_key_o = 32'(out_key_q);
  assign last_out_o   = out_last_q;
  assign dropped_o    = out_drop_q;

endmodule

@@ hdl/heap_sort_engine_unit.sv @@
// Top level of the heap sort engine: joins the sequencer and the datapath.
// Depends on hse_pkg, hse_ctrl, hse_dpath (and through it hse_ram).
//
// Channel   Direction  Handshake               Payload
// -------   ---------  ---------               -------
// in        sink       in_valid_i/in_ready_o   key_value_i[31:0], last_in_i
// out       source     out_valid_o/out_ready_i sorted_key_o[31:0], last_out_o, dropped_o
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_data_i (signed_keys)
//
// While a set loads, keys are accepted back to back. The transaction marked
// last starts the sort on the single-write, single-read heap RAM: the heap is
// built node by node, each extraction swaps the root out and sifts down, and each
// sorted key is then read out in turn, held while the output stalls.
// Reset clears counters, the overflow flag, the signed mode and the output valid;
// heap contents are not cleared and only entries written in the current set are read.
// Input is held off (in_ready_o low) from the last transaction of a set until its
// final result has been taken; configuration writes are accepted in any cycle.
module heap_sort_engine_unit
  import hse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] key_value_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sorted_key_o,
  output logic        last_out_o,
  output logic        dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // The mode register is a plain flop, so a write never has to wait.
  assign cfg_ready_o = 1'b1;

  hse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .last_in_i (last_in_i),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  hse_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .key_value_i (key_value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sorted_key_o(sorted_key_o),
    .last_out_o  (last_out_o),
    .dropped_o   (dropped_o)
  );

`ifndef SYNTHESIS
  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // A last transaction closes the set and stops intake.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_in_i) |=> !in_ready_o)
    else $error("input still ready after last key");

  // The final result hands the engine back to loading.
  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_out_o) |=> in_ready_o)
    else $error("engine not ready after final result");

  // Mid-set results keep intake closed.
  a_mid_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_out_o) |=> !in_ready_o)
    else $error("input reopened before final result");
`endif

endmodule

@@ tb/sv/heap_sort_engine_unit_tb.sv @@
// Self-checking testbench for heap_sort_engine_unit: streams key sets in, predicts
// the ascending output of every set and checks each sorted result as it is taken.
// Depends on hse_pkg for the key type and the store capacity.
module heap_sort_engine_unit_tb;
  import hse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam int KEY_TARGET    = 400;  // keys in all, directed ones included
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    key_t key;
    logic last;
  } key_item_t;

  typedef struct {
    key_t key;
    logic last;
    logic dropped;
  } sorted_result_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [31:0] key_value_i  = '0;
  logic        last_in_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] sorted_key_o;
  logic        last_out_o;
  logic        dropped_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i   = 1'b0;

  // Keys waiting to be driven, and sorted keys the engine still owes us.
  key_item_t      key_queue[$];
  sorted_result_t sorted_keys_due[$];

  // Mirror of the engine: keys of the open set, its overflow flag, the compare mode.
  key_t held_keys[MAX_KEYS];
  int   held_count    = 0;
  logic held_overflow = 1'b0;
  logic sign_mode     = 1'b0;

  // Handshake flags: raised by the monitor at the rising edge, cleared by the
  // process that owns the channel at the following falling edge.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  logic cfg_taken = 1'b0;

  logic in_steady  = 1'b0;
  logic out_steady = 1'b0;

  int keys_sent   = 0;
  int keys_taken  = 0;
  int idle_cycles = 0;
  int error_count = 0;

  key_t unsigned_set[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'h1234_5678};
  key_t signed_set[6]   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                            32'h0000_0001, 32'hFFFF_FFFF};

  heap_sort_engine_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_value_i  (key_value_i),
    .last_in_i    (last_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sorted_key_o (sorted_key_o),
    .last_out_o   (last_out_o),
    .dropped_o    (dropped_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap(logic steady);
    return steady ? 0 : $urandom_range(0, 12);
  endfunction

  // Bias keys towards the sign boundary and small values so that equal keys and
  // signed/unsigned ordering differences turn up often.
  function automatic key_t draw_key();
    case ($urandom_range(0, 5))
      0:       return key_t'($urandom_range(0, 7));
      1:       return 32'hFFFF_FFF8 + key_t'($urandom_range(0, 7));
      2:       return 32'h8000_0000 + key_t'($urandom_range(0, 7));
      3:       return 32'h7FFF_FFF8 + key_t'($urandom_range(0, 7));
      default: return key_t'($urandom);
    endcase
  endfunction

  task automatic log_error(string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  task automatic queue_key(key_t key, logic last);
    key_queue.push_back('{key, last});
    keys_sent++;
  endtask

  task automatic queue_set(int count);
    for (int n = 0; n < count; n++) queue_key(draw_key(), n == count - 1);
  endtask

  // Hold until every queued key is taken and every sorted key has come back,
  // then let the engine settle before the next register write.
  task automatic drain_and_settle();
    do @(negedge clk_i); while (keys_taken != keys_sent || sorted_keys_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_sign_mode(logic mode);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_taken = 1'b0;
    cfg_valid_i <= 1'b0;
  endtask

  // Key driver: present one queued key, hold it until the transaction completes,
  // then idle for a drawn number of cycles before the next.
  always @(negedge clk_i) begin
    key_item_t next_item;
    logic      loaded;
    int        in_gap;
    if (!rst_ni) begin
      loaded = 1'b0;
      in_gap = 0;
      in_valid_i <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        loaded   = 1'b0;
        in_gap   = draw_gap(in_steady);
      end
      if (!loaded) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (key_queue.size() != 0) begin
          next_item = key_queue.pop_front();
          key_value_i <= next_item.key;
          last_in_i   <= next_item.last;
          loaded = 1'b1;
        end
      end
      in_valid_i <= loaded;
    end
  end

  // Result sink: after each taken result, stall ready for a drawn number of cycles.
  always @(negedge clk_i) begin
    int out_wait;
    if (!rst_ni) begin
      out_wait = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait  = draw_gap(out_steady);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: sample every channel at the rising edge, keep the mirror in step with
  // accepted keys and register writes, and check results against the sorted list.
  always @(posedge clk_i) begin
    sorted_result_t due;
    key_t           pick;
    int             j;
    logic           moved;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        sign_mode = cfg_data_i;
        cfg_taken = 1'b1;
        moved     = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        out_taken = 1'b1;
        moved     = 1'b1;
        if (sorted_keys_due.size() == 0) begin
          log_error($sformatf("unexpected result: key %h last %b dropped %b",
                              sorted_key_o, last_out_o, dropped_o));
        end else begin
          due = sorted_keys_due.pop_front();
          if (sorted_key_o !== due.key || last_out_o !== due.last ||
              dropped_o !== due.dropped) begin
            log_error($sformatf({"result mismatch: expected key %h last %b dropped %b,",
                                 " got key %h last %b dropped %b"},
                                due.key, due.last, due.dropped,
                                sorted_key_o, last_out_o, dropped_o));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        moved    = 1'b1;
        keys_taken++;
        // Store while there is room, otherwise drop the key and flag the set.
        if (held_count < MAX_KEYS) begin
          held_keys[held_count] = key_value_i;
          held_count++;
        end else begin
          held_overflow = 1'b1;
        end
        if (last_in_i) begin
          // Equal keys are indistinguishable, so any ascending sort gives the
          // same sequence as the engine's heapsort.
          for (int i = 1; i < held_count; i++) begin
            pick = held_keys[i];
            j    = i;
            while (j > 0 && (sign_mode ? ($signed(held_keys[j-1]) > $signed(pick))
                                       : (held_keys[j-1] > pick))) begin
              held_keys[j] = held_keys[j-1];
              j--;
            end
            held_keys[j] = pick;
          end
          for (int i = 0; i < held_count; i++)
            sorted_keys_due.push_back('{held_keys[i], i == held_count - 1, held_overflow});
          held_count    = 0;
          held_overflow = 1'b0;
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: end the run if no transaction completes on any channel for too long.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("heap_sort_engine_unit_tb: errors");
    $finish;
  end

  initial begin
    int set_count;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: unsigned ordering of the extremes, a lone key, duplicates.
    write_sign_mode(1'b0);
    queue_key(32'hFFFF_FFFF, 1'b1);
    foreach (unsigned_set[i]) queue_key(unsigned_set[i], i == 7);
    drain_and_settle();

    // Directed: the same boundary keys under signed ordering.
    write_sign_mode(1'b1);
    foreach (signed_set[i]) queue_key(signed_set[i], i == 5);
    drain_and_settle();

    // Capacity: a set that fills the store exactly, then sets one and two keys over
    // capacity, whose surplus keys are dropped, with the last marker still ending the set.
    write_sign_mode($urandom_range(0, 1));
    queue_set(MAX_KEYS);
    queue_set(MAX_KEYS + 1);
    queue_set(MAX_KEYS + 2);
    drain_and_settle();

    // Random phases: fresh compare mode and flow pattern each time, mostly small
    // sets with the odd one near or beyond capacity.
    while (keys_sent < KEY_TARGET) begin
      write_sign_mode($urandom_range(0, 1));
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      set_count  = $urandom_range(1, 4);
      for (int s = 0; s < set_count; s++) begin
        if ($urandom_range(0, 9) == 0) queue_set($urandom_range(MAX_KEYS - 4, MAX_KEYS + 6));
        else queue_set($urandom_range(1, 12));
      end
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("heap_sort_engine_unit_tb: clean");
    end else begin
      $display("heap_sort_engine_unit_tb: errors");
    end
    $finish;
  end

endmodule
